// ===== hdl/mcpbm_pkg.sv =====
`default_nettype none
package mcpbm_pkg;

    // field widths
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned LOGICAL_W = 7;
    localparam int unsigned BANK_W    = 8;
    localparam int unsigned OFFSET_W  = 22;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_CONFLICT_ENABLE = 8'd1;

    // reset and special bank counts
    localparam logic [COUNT_W-1:0]   RESET_BANK_COUNT = 8'd32;
    localparam logic [COUNT_W-1:0]   FOLD_BANK_COUNT  = 8'd96;
    localparam logic [LOGICAL_W-1:0] FOLD_DISTANCE    = 7'h20;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOW_GO,
        ST_LOW_WAIT,
        ST_HIGH_GO,
        ST_HIGH_WAIT
    } seq_state_t;

    // request to the remainder unit
    typedef struct packed {
        logic                 start;
        logic [LOGICAL_W-1:0] dividend;
        logic [COUNT_W-1:0]   divisor;
    } mod_req_t;

    // answer from the remainder unit
    typedef struct packed {
        logic              done;
        logic [BANK_W-1:0] remainder;
    } mod_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/mcpbm_mod_unit.sv =====
`default_nettype none
module mcpbm_mod_unit
    import mcpbm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mod_req_t req,
    output mod_rsp_t      rsp
);

    localparam logic [2:0] LAST_STEP = 3'(LOGICAL_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [2:0]           step_reg;
    logic [LOGICAL_W-1:0] dvd_reg;
    logic [COUNT_W-1:0]   dsr_reg;
    logic [BANK_W-1:0]    rem_reg;

    logic [BANK_W:0]      trial;
    logic [BANK_W:0]      diff;
    logic                 fits;

    // one restoring remainder step per cycle
    always_comb
    begin
        trial = {rem_reg, dvd_reg[LOGICAL_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                step_reg <= '0;
                if (req.divisor == '0 || req.divisor == FOLD_BANK_COUNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            if (req.divisor == '0)
            begin
                rem_reg <= '0;
            end
            else if (req.divisor == FOLD_BANK_COUNT)
            begin
                // 0x20-0x3f fold back onto the first 32 banks
                if (req.dividend >= FOLD_DISTANCE)
                    rem_reg <= BANK_W'(req.dividend - FOLD_DISTANCE);
                else
                    rem_reg <= BANK_W'(req.dividend);
            end
            else
            begin
                rem_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[LOGICAL_W-2:0], 1'b0};
            rem_reg <= fits ? diff[BANK_W-1:0] : trial[BANK_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule
`default_nettype wire

// ===== hdl/multicart_prg_bank_mapper_unit.sv =====
`default_nettype none
// Multicart PRG bank mapper: each item is one CPU bus access and gives one result
// item with the PRG ROM offset for $8000-$FFFF (tuser flags it as handled) and the
// mirroring bit after the access. A mapper register write makes the block busy while
// both 16 KiB windows are recomputed by one shared remainder unit that takes seven
// shift-subtract steps per bank, once in 16 KiB repeat mode and once per window in
// 32 KiB pair mode; with a bank count of 0 or 96 the unit skips the steps. A write
// to the bank count register triggers the same recomputation. A new item is taken
// only when the block is not busy and the output register is empty or its waiting
// result leaves at the same clock edge.
module multicart_prg_bank_mapper_unit
    import mcpbm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // access items
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [31:0]          s_axis_tdata,  // cpu_addr, write_data, rom_byte
    input  wire logic                 s_axis_tuser,  // func
    // result items
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [23:0]               m_axis_tdata,  // rom_offset, mirror_vertical, pad
    output logic                      m_axis_tuser,  // handled
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    seq_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] bank_count_reg;
    logic               conflict_en_reg;
    logic [7:0]         reg_low_reg, reg_low_next;
    logic               reg_high_reg, reg_high_next;
    logic [BANK_W-1:0]  window_reg [2];
    logic               out_valid_reg;
    logic               out_handled_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic               out_mirror_reg;

    mod_req_t           mod_req;
    mod_rsp_t           mod_rsp;

    logic               in_fire;
    logic               cfg_fire;
    logic               is_write;
    logic [15:0]        cpu_addr;
    logic [7:0]         write_data;
    logic [7:0]         rom_byte;
    logic               handled;
    logic               reg_write;
    logic [7:0]         eff_data;
    logic [OFFSET_W-1:0] offset;
    logic [LOGICAL_W-1:0] logical;
    logic               repeat_mode;

    // input unpacking
    assign is_write   = s_axis_tuser;
    assign cpu_addr   = s_axis_tdata[15:0];
    assign write_data = s_axis_tdata[23:16];
    assign rom_byte   = s_axis_tdata[31:24];

    // handshakes
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_fire      = cfg_valid && cfg_ready;

    // access decode and register update
    always_comb
    begin
        handled       = cpu_addr[15];
        reg_write     = in_fire && handled && is_write;
        eff_data      = conflict_en_reg ? (write_data & rom_byte) : write_data;
        offset        = handled ? {window_reg[cpu_addr[14]], cpu_addr[13:0]} : '0;
        reg_low_next  = reg_low_reg;
        reg_high_next = reg_high_reg;
        if (reg_write)
        begin
            if (cpu_addr[0])
                reg_high_next = eff_data[0];
            else
                reg_low_next = eff_data;
        end
    end

    // logical bank and mode from the mapper registers
    assign logical     = {reg_high_reg, reg_low_reg[7], reg_low_reg[4:0]};
    assign repeat_mode = reg_low_reg[5];

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        mod_req.start    = 1'b0;
        mod_req.divisor  = bank_count_reg;
        mod_req.dividend = logical;
        case (state_reg)
            ST_IDLE:
            begin
                if (reg_write || (cfg_fire && cfg_index == CFG_PRG_BANK_COUNT))
                    state_next = ST_LOW_GO;
            end
            ST_LOW_GO:
            begin
                mod_req.start    = 1'b1;
                mod_req.dividend = repeat_mode ? logical : (logical & 7'h7E);
                state_next       = ST_LOW_WAIT;
            end
            ST_LOW_WAIT:
            begin
                if (mod_rsp.done)
                    state_next = repeat_mode ? ST_IDLE : ST_HIGH_GO;
            end
            ST_HIGH_GO:
            begin
                mod_req.start    = 1'b1;
                mod_req.dividend = logical | 7'h01;
                state_next       = ST_HIGH_WAIT;
            end
            ST_HIGH_WAIT:
            begin
                if (mod_rsp.done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // shared remainder unit
    mcpbm_mod_unit u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // state, configuration and mapper registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            bank_count_reg  <= RESET_BANK_COUNT;
            conflict_en_reg <= 1'b0;
            reg_low_reg     <= '0;
            reg_high_reg    <= 1'b0;
            window_reg[0]   <= BANK_W'(0);
            window_reg[1]   <= BANK_W'(1);
        end
        else
        begin
            state_reg    <= state_next;
            reg_low_reg  <= reg_low_next;
            reg_high_reg <= reg_high_next;
            if (cfg_fire)
            begin
                if (cfg_index == CFG_PRG_BANK_COUNT)
                    bank_count_reg <= cfg_data;
                else if (cfg_index == CFG_BUS_CONFLICT_ENABLE)
                    conflict_en_reg <= cfg_data[0];
            end
            if (mod_rsp.done && state_reg == ST_LOW_WAIT)
            begin
                window_reg[0] <= mod_rsp.remainder;
                if (repeat_mode)
                    window_reg[1] <= mod_rsp.remainder;
            end
            if (mod_rsp.done && state_reg == ST_HIGH_WAIT)
                window_reg[1] <= mod_rsp.remainder;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_handled_reg <= handled;
            out_offset_reg  <= offset;
            out_mirror_reg  <= reg_low_next[6];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_handled_reg;
    assign m_axis_tdata  = {1'b0, out_mirror_reg, out_offset_reg};

endmodule
`default_nettype wire
